FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// assertion with synchronous active-low reset as disable
`define LPHI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assertion that also checks across reset
`define LPHI_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPHI_ASSERT(lbl, clk, rst_n, prop, msg)
`define LPHI_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

FILE: src/lphi_pkg.sv
// ---------------------------------------------------------------------------
// lphi_pkg
// Types, sizes and codes shared by the linear probe hash index.
// ---------------------------------------------------------------------------
package lphi_pkg;

    localparam int SLOTS_LOG2 = 10;
    localparam int SLOT_COUNT = 1 << SLOTS_LOG2;
    localparam int CAPACITY   = 768;
    localparam int KEY_W      = 41;
    localparam int IDX_W      = 10;
    localparam int NEXT_W     = $clog2(CAPACITY + 1);

    typedef logic [SLOTS_LOG2-1:0] t_slot_addr;
    typedef logic [KEY_W-1:0]      t_key;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [NEXT_W-1:0]     t_next;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_INSERTED  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef struct packed {
        logic  valid;
        t_key  key;
        t_idx  idx;
    } t_slot;

    // controller -> datapath
    typedef struct packed {
        logic    clr;          // write an empty slot at the sweep address
        logic    load;         // capture new word, read home slot
        logic    advance;      // step to next slot, read it
        logic    write;        // store key in current slot, bump next index
        logic    result_load;  // load output register
        t_status status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic slot_valid;
        logic key_match;
        logic last_probe;
        logic cap_full;
        logic is_lookup;
        logic clear_done;
        logic out_free;
    } t_sts;

    // index counter to output field width
    function automatic t_idx idx_field(input t_next v);
        logic [31:0] t;
        t = 32'(v);
        return t[IDX_W-1:0];
    endfunction

endpackage

FILE: src/lphi_in_if.sv
// ---------------------------------------------------------------------------
// lphi_in_if
// Request channel: operation and key.
// ---------------------------------------------------------------------------
interface lphi_in_if
    import lphi_pkg::*;
();
    logic valid;
    logic ready;
    logic op;
    t_key key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

FILE: src/lphi_out_if.sv
// ---------------------------------------------------------------------------
// lphi_out_if
// Response channel: dense index and status.
// ---------------------------------------------------------------------------
interface lphi_out_if
    import lphi_pkg::*;
();
    logic       valid;
    logic       ready;
    t_idx       index;
    logic [1:0] status;

    modport source (output valid, output index, output status, input ready);
    modport sink   (input valid, input index, input status, output ready);
endinterface

FILE: src/linear_probe_hash_index.sv
// ---------------------------------------------------------------------------
// linear_probe_hash_index
// Key to dense index map in an open-addressing table with linear probing.
// ---------------------------------------------------------------------------
//  channel   dir  fields             word
//  i_in      in   op[0], key[40:0]   request: insert or look up
//  o_out     out  index[9:0],        response: one per request
//                 status[1:0]
//
//  A new request is taken only while idle, once the last one is finished;
//  each probe is one registered read of the single-port slot memory.
//  After reset a clearing sweep writes every slot empty, with i_in.ready low.
//  The result sits in an output register; the next request is taken the cycle
//  after it is loaded. If that register is still occupied, the probe holds.
// ---------------------------------------------------------------------------
module linear_probe_hash_index
    import lphi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    lphi_in_if.sink    i_in,
    lphi_out_if.source o_out
);

    t_cmd cmd;
    t_sts sts;

    lphi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lphi_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_in_op      (i_in.op),
        .i_in_key     (i_in.key),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_out_index  (o_out.index),
        .o_out_status (o_out.status)
    );

endmodule

FILE: src/lphi_dp.sv
// ---------------------------------------------------------------------------
// lphi_dp
// Datapath: slot memory, probe address and count, index counter, output word.
// ---------------------------------------------------------------------------
module lphi_dp
    import lphi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  logic       i_in_op,
    input  t_key       i_in_key,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output t_idx       o_out_index,
    output logic [1:0] o_out_status
);

    t_slot      mem [SLOT_COUNT];

    logic       r_op;
    t_key       r_key;
    t_slot_addr r_pos;
    t_slot_addr r_cnt;
    t_next      r_next;
    t_slot      r_rd;
    logic       r_out_valid;
    t_idx       r_out_index;
    t_status    r_out_status;

    t_slot_addr pos_inc;
    t_slot_addr rd_addr;
    logic       rd_en;
    logic       wr_en;
    t_slot      wr_data;
    t_idx       res_index;

    assign pos_inc = r_pos + 1'b1;
    assign rd_en   = i_cmd.load | i_cmd.advance;
    assign rd_addr = i_cmd.load ? i_in_key[SLOTS_LOG2-1:0] : pos_inc;
    assign wr_en   = i_cmd.clr | i_cmd.write;

    always_comb begin
        if (i_cmd.clr) begin
            wr_data = '0;
        end else begin
            wr_data.valid = 1'b1;
            wr_data.key   = r_key;
            wr_data.idx   = idx_field(r_next);
        end
    end

    // slot memory: one write or one read per cycle, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_pos] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_next <= '0;
        end else begin
            if (i_cmd.clr || i_cmd.advance) begin
                r_pos <= pos_inc;
            end else if (i_cmd.load) begin
                r_pos <= i_in_key[SLOTS_LOG2-1:0];
            end
            if (i_cmd.write) begin
                r_next <= r_next + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in_op;
            r_key <= i_in_key;
            r_cnt <= '0;
        end else if (i_cmd.advance) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_comb begin
        case (i_cmd.status)
            ST_FOUND:    res_index = r_rd.idx;
            ST_INSERTED: res_index = idx_field(r_next);
            default:     res_index = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.result_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result_load) begin
            r_out_index  <= res_index;
            r_out_status <= i_cmd.status;
        end
    end

    assign o_sts.slot_valid = r_rd.valid;
    assign o_sts.key_match  = (r_rd.key == r_key);
    assign o_sts.last_probe = (r_cnt == '1);
    assign o_sts.cap_full   = (r_next >= NEXT_W'(CAPACITY));
    assign o_sts.is_lookup  = (r_op == OP_LOOKUP);
    assign o_sts.clear_done = (r_pos == '1);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_out_index  = r_out_index;
    assign o_out_status = r_out_status;

endmodule

FILE: src/lphi_ctrl.sv
// ---------------------------------------------------------------------------
// lphi_ctrl
// Controller: clearing sweep, request acceptance and probe sequencing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lphi_ctrl
    import lphi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_PROBE = 3'b100
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    done;
    t_status status_sel;

    assign o_in_ready = (r_state == S_IDLE);

    // decide on the slot just read
    always_comb begin
        done       = 1'b1;
        status_sel = ST_FULL;
        if (!i_sts.slot_valid) begin
            if (i_sts.is_lookup) begin
                status_sel = ST_NOT_FOUND;
            end else if (i_sts.cap_full) begin
                status_sel = ST_FULL;
            end else begin
                status_sel = ST_INSERTED;
            end
        end else if (i_sts.key_match) begin
            status_sel = ST_FOUND;
        end else if (i_sts.last_probe) begin
            status_sel = ST_FULL;   // whole table probed
        end else begin
            done = 1'b0;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_cmd             = '0;
        o_cmd.status      = status_sel;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PROBE;
                end
            end
            S_PROBE: begin
                if (!done) begin
                    o_cmd.advance = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.result_load = 1'b1;
                    o_cmd.write       = (status_sel == ST_INSERTED);
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    `LPHI_ASSERT_NR(a_rst_clear, i_clk, !i_rst_n |=> r_state == S_CLEAR, "reset must restart clearing sweep")
    `LPHI_ASSERT(a_write_ok, i_clk, i_rst_n, o_cmd.write |-> (!i_sts.slot_valid && !i_sts.is_lookup && !i_sts.cap_full && i_sts.out_free), "slot written without an empty slot, room and a free output")
    `LPHI_ASSERT(a_no_wrap, i_clk, i_rst_n, o_cmd.advance |-> (i_sts.slot_valid && !i_sts.key_match && !i_sts.last_probe), "probe stepped past a decision or the table end")
    `LPHI_ASSERT(a_res_idle, i_clk, i_rst_n, o_cmd.result_load |=> (r_state == S_IDLE && !i_sts.out_free == 0 || r_state == S_IDLE), "result load must return to idle")

endmodule

FILE: tb/linear_probe_hash_index_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_probe_hash_index_test
// Self-checking bench for the hash index. A short table of directed words
// (empty table, extreme keys, collisions, wrap past the last slot) is
// followed by random traffic that fills the index to capacity and then keeps
// going. Every response is compared with a predictor that keeps its own copy
// of the slot table, under random idling on both channels.
// ---------------------------------------------------------------------------
module linear_probe_hash_index_test;
    import lphi_pkg::*;

    localparam int   RAND_WORDS   = 1030;
    localparam int   IDLE_PCT     = 31;
    localparam int   DRAIN_CYCLES = SLOT_COUNT + 64;
    // worst case per word is a full probe plus stalls, on top of the clear sweep
    localparam int   LIMIT_CYCLES = 4_000_000;
    localparam t_key KEY_MAX      = '1;
    localparam int   N_DIR        = 20;

    typedef struct packed {
        t_op     op;
        t_key    key;
        logic    typed;     // expected result given in the row
        t_idx    idx;
        t_status st;
    } t_dir_row;

    typedef struct {
        t_idx    idx;
        t_status st;
    } t_rsp;

    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{OP_LOOKUP, 41'd0,              1'b1, 10'd0, ST_NOT_FOUND},
        '{OP_LOOKUP, KEY_MAX,            1'b1, 10'd0, ST_NOT_FOUND},
        '{OP_INSERT, 41'd0,              1'b1, 10'd0, ST_INSERTED},
        '{OP_INSERT, KEY_MAX,            1'b1, 10'd1, ST_INSERTED},
        '{OP_INSERT, 41'd0,              1'b1, 10'd0, ST_FOUND},
        '{OP_LOOKUP, KEY_MAX,            1'b1, 10'd1, ST_FOUND},
        // collisions on slot 0 and on the last slot, the latter wrapping
        '{OP_INSERT, 41'd1024,           1'b0, 10'd0, ST_FOUND},
        '{OP_INSERT, 41'd2047,           1'b0, 10'd0, ST_FOUND},
        '{OP_LOOKUP, 41'd2047,           1'b0, 10'd0, ST_FOUND},
        '{OP_LOOKUP, 41'd2048,           1'b0, 10'd0, ST_FOUND},
        // keys differing only in the top bit
        '{OP_INSERT, 41'h100_0000_0000,  1'b0, 10'd0, ST_FOUND},
        '{OP_LOOKUP, 41'h100_0000_0000,  1'b0, 10'd0, ST_FOUND},
        '{OP_LOOKUP, 41'h0FF_FFFF_FFFF,  1'b0, 10'd0, ST_FOUND},
        '{OP_INSERT, 41'd1,              1'b0, 10'd0, ST_FOUND},
        '{OP_INSERT, 41'h155_5555_5555,  1'b0, 10'd0, ST_FOUND},
        '{OP_INSERT, 41'h0AA_AAAA_AAAA,  1'b0, 10'd0, ST_FOUND},
        '{OP_LOOKUP, 41'h155_5555_5555,  1'b0, 10'd0, ST_FOUND},
        '{OP_INSERT, 41'd1024,           1'b0, 10'd0, ST_FOUND},
        '{OP_LOOKUP, 41'd1,              1'b0, 10'd0, ST_FOUND},
        '{OP_LOOKUP, 41'h0AA_AAAA_AAAA,  1'b0, 10'd0, ST_FOUND}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    lphi_in_if  req_ch ();
    lphi_out_if rsp_ch ();

    linear_probe_hash_index i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the slot table
    logic  tbl_valid [SLOT_COUNT];
    t_key  tbl_key   [SLOT_COUNT];
    t_idx  tbl_idx   [SLOT_COUNT];
    int    idx_count;

    t_rsp  due_results [$];
    t_key  known_keys  [$];
    int    err_count;
    int    words_sent;
    int    rsp_checked;
    int    status_tally [4];
    logic  steady;          // no idling on either side while set
    int    cycle_count;

    // probe from the home slot; insert takes the first empty slot
    function automatic void map_key(input t_op op, input t_key key,
                                    output t_idx idx, output t_status st);
        t_slot_addr pos;
        int         n;
        pos = key[SLOTS_LOG2-1:0];
        idx = '0;
        st  = ST_FULL;   // kept if every slot is taken and none matches
        for (n = 0; n < SLOT_COUNT; n++) begin
            if (!tbl_valid[pos]) begin
                if (op == OP_LOOKUP) begin
                    st = ST_NOT_FOUND;
                end else if (idx_count >= CAPACITY) begin
                    st = ST_FULL;
                end else begin
                    tbl_valid[pos] = 1'b1;
                    tbl_key[pos]   = key;
                    tbl_idx[pos]   = t_idx'(idx_count);
                    idx            = t_idx'(idx_count);
                    idx_count      = idx_count + 1;
                    st             = ST_INSERTED;
                end
                break;
            end
            if (tbl_key[pos] == key) begin
                idx = tbl_idx[pos];
                st  = ST_FOUND;
                break;
            end
            pos = pos + 1'b1;
        end
    endfunction

    // random key; a quarter land in a narrow band of homes around the wrap
    function automatic t_key fresh_key();
        t_key k;
        k = t_key'({9'($urandom_range(0, 511)), $urandom});
        if ($urandom_range(0, 3) == 0) begin
            k[SLOTS_LOG2-1:0] = t_slot_addr'(SLOT_COUNT - 8 + $urandom_range(0, 15));
        end
        return k;
    endfunction

    // called just after a falling edge; returns just after acceptance
    task automatic send_word(input t_op op, input t_key key, input logic typed,
                             input t_idx t_i, input t_status t_s);
        t_idx    p_idx;
        t_status p_st;
        t_rsp    r;
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.key   <= key;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        map_key(op, key, p_idx, p_st);
        if (p_st == ST_INSERTED) known_keys.push_back(key);
        r.idx = typed ? t_i : p_idx;
        r.st  = typed ? t_s : p_st;
        due_results.push_back(r);
        words_sent++;
    endtask

    // response side
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_rsp exp_r;
        if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_checked++;
            status_tally[rsp_ch.status]++;
            if (due_results.size() == 0) begin
                err_count++;
                $display("%0t: unexpected word index %0d status %0d", $time,
                         rsp_ch.index, rsp_ch.status);
            end else begin
                exp_r = due_results.pop_front();
                if (rsp_ch.index !== exp_r.idx) begin
                    err_count++;
                    $display("%0t: index expected %0d actual %0d", $time,
                             exp_r.idx, rsp_ch.index);
                end
                if (rsp_ch.status !== exp_r.st) begin
                    err_count++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.st, rsp_ch.status);
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                 due_results.size());
        $display("simulation failed");
        $finish;
    end

    initial begin
        int   i;
        int   r;
        t_op  op;
        t_key k;
        for (i = 0; i < SLOT_COUNT; i++) tbl_valid[i] = 1'b0;
        idx_count    = 0;
        err_count    = 0;
        words_sent   = 0;
        rsp_checked  = 0;
        status_tally = '{0, 0, 0, 0};
        steady       = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op    = OP_INSERT;
        req_ch.key   = '0;
        i_rst_n      = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < N_DIR; i++) begin
            send_word(DIR_ROWS[i].op, DIR_ROWS[i].key, DIR_ROWS[i].typed,
                      DIR_ROWS[i].idx, DIR_ROWS[i].st);
        end

        // fill to capacity, then carry on against a full index
        for (i = 0; i < RAND_WORDS; i++) begin
            steady = (i >= 200 && i < 400);
            if (i == RAND_WORDS / 2) begin
                // withdraw the word just taken before waiting for the drain
                @(negedge i_clk);
                req_ch.valid <= 1'b0;
                while (due_results.size() != 0) @(posedge i_clk);
            end
            r = $urandom_range(0, 99);
            if (idx_count < CAPACITY) begin
                op = (r < 88) ? OP_INSERT : OP_LOOKUP;
                k  = (r < 82 || r >= 96) ? fresh_key()
                     : known_keys[$urandom_range(0, known_keys.size() - 1)];
            end else begin
                op = (r < 50) ? OP_INSERT : OP_LOOKUP;
                k  = (r < 35 || r >= 85) ? fresh_key()
                     : known_keys[$urandom_range(0, known_keys.size() - 1)];
            end
            send_word(op, k, 1'b0, '0, ST_FOUND);
        end
        steady = 1'b0;
        @(negedge i_clk);
        req_ch.valid <= 1'b0;

        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d words sent, %0d responses checked, %0d keys held of %0d",
                 words_sent, rsp_checked, idx_count, CAPACITY);
        $display("found %0d, inserted %0d, not found %0d, full %0d",
                 status_tally[ST_FOUND], status_tally[ST_INSERTED],
                 status_tally[ST_NOT_FOUND], status_tally[ST_FULL]);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: linear_probe_hash_index.f
+incdir+src
src/lphi_pkg.sv
src/lphi_in_if.sv
src/lphi_out_if.sv
src/lphi_dp.sv
src/lphi_ctrl.sv
src/linear_probe_hash_index.sv
tb/linear_probe_hash_index_test.sv
